// ----- hw/rtl/fall_detector_fsm_macros.svh -----
// assertion macros for the fall detector
// no dependencies; included by the top level only
`ifndef FALL_DETECTOR_FSM_MACROS_SVH
`define FALL_DETECTOR_FSM_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define FDET_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define FDET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/fdet_pkg.sv -----
// shared types and constants for the fall detector
// no dependencies; used by the interfaces, fdet_mag and fall_detector_fsm
package fdet_pkg;

   localparam int unsigned AXIS_W  = 16;
   localparam int unsigned MAG_W   = 32;
   localparam int unsigned TICK_W  = 32;
   localparam int unsigned SPAN_W  = 31;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned CODE_W  = 2;

   // detector phases, one-hot
   typedef enum logic [3:0] {
      PH_IDLE        = 4'b0001,
      PH_FREEFALL    = 4'b0010,
      PH_IMPACT_WAIT = 4'b0100,
      PH_POST        = 4'b1000
   } phase_type;

   // external phase codes
   localparam logic [CODE_W-1:0] CODE_IDLE        = 2'd0;
   localparam logic [CODE_W-1:0] CODE_FREEFALL    = 2'd1;
   localparam logic [CODE_W-1:0] CODE_IMPACT_WAIT = 2'd2;
   localparam logic [CODE_W-1:0] CODE_POST        = 2'd3;

   // register indexes
   typedef enum logic [INDEX_W-1:0] {
      REG_FREEFALL_MAG_SQ    = 3'd0,
      REG_IMPACT_MAG_SQ      = 3'd1,
      REG_STILL_RATE_SQ      = 3'd2,
      REG_FREEFALL_MAX_TICKS = 3'd3,
      REG_IMPACT_WAIT_TICKS  = 3'd4,
      REG_POST_WINDOW_TICKS  = 3'd5,
      REG_REPORT_GAP_TICKS   = 3'd6
   } reg_index_type;

   localparam logic [MAG_W-1:0]  RST_FREEFALL_MAG_SQ    = 32'd4194304;
   localparam logic [MAG_W-1:0]  RST_IMPACT_MAG_SQ      = 32'd104857600;
   localparam logic [MAG_W-1:0]  RST_STILL_RATE_SQ      = 32'd42902500;
   localparam logic [SPAN_W-1:0] RST_FREEFALL_MAX_TICKS = 31'd500;
   localparam logic [SPAN_W-1:0] RST_IMPACT_WAIT_TICKS  = 31'd1000;
   localparam logic [SPAN_W-1:0] RST_POST_WINDOW_TICKS  = 31'd2000;
   localparam logic [SPAN_W-1:0] RST_REPORT_GAP_TICKS   = 31'd5000;

   function automatic logic [CODE_W-1:0] phase_code(input phase_type ph);
      logic [CODE_W-1:0] code;
      unique case (ph)
         PH_IDLE:        code = CODE_IDLE;
         PH_FREEFALL:    code = CODE_FREEFALL;
         PH_IMPACT_WAIT: code = CODE_IMPACT_WAIT;
         PH_POST:        code = CODE_POST;
         default:        code = CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

// ----- hw/rtl/fdet_if.sv -----
// channel interfaces of the fall detector: sample, result and register write
// depends on fdet_pkg
interface fdet_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [fdet_pkg::AXIS_W-1:0]       accel_x;
   logic signed [fdet_pkg::AXIS_W-1:0]       accel_y;
   logic signed [fdet_pkg::AXIS_W-1:0]       accel_z;
   logic signed [fdet_pkg::AXIS_W-1:0]       gyro_x;
   logic signed [fdet_pkg::AXIS_W-1:0]       gyro_y;
   logic signed [fdet_pkg::AXIS_W-1:0]       gyro_z;
   logic        [fdet_pkg::TICK_W-1:0]       timestamp;

   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   timestamp, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 timestamp, output ready);
endinterface

interface fdet_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             fall_alarm;
   logic [fdet_pkg::CODE_W-1:0]      detector_state;

   modport source (output valid, fall_alarm, detector_state, input ready);
   modport sink (input valid, fall_alarm, detector_state, output ready);
endinterface

interface fdet_csr_if;
   logic                             valid;
   logic                             ready;
   logic [fdet_pkg::INDEX_W-1:0]     index;
   logic [fdet_pkg::MAG_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/fdet_mag.sv -----
// squared magnitude of a three-axis signed vector, exact, no root
// depends on fdet_pkg
module fdet_mag (
   input  logic signed [fdet_pkg::AXIS_W-1:0] axis_x,
   input  logic signed [fdet_pkg::AXIS_W-1:0] axis_y,
   input  logic signed [fdet_pkg::AXIS_W-1:0] axis_z,
   output logic        [fdet_pkg::MAG_W-1:0]  mag_sq
);
   import fdet_pkg::*;

   logic signed [2*AXIS_W-1:0] sq_x;
   logic signed [2*AXIS_W-1:0] sq_y;
   logic signed [2*AXIS_W-1:0] sq_z;

   assign sq_x = axis_x * axis_x;
   assign sq_y = axis_y * axis_y;
   assign sq_z = axis_z * axis_z;

   // each square is at most 2^30, so the sum of three fits in 32 bits
   assign mag_sq = MAG_W'(unsigned'(sq_x)) + MAG_W'(unsigned'(sq_y))
                 + MAG_W'(unsigned'(sq_z));

endmodule

// ----- hw/rtl/fall_detector_fsm.sv -----
//  channel | direction | word                                   | accepted when
//  req_bus | in        | accel xyz, gyro xyz, timestamp         | valid && ready
//  rsp_bus | out       | fall_alarm, detector_state             | valid && ready
//  csr_bus | in        | register index, write data             | valid (ready tied high)
//
// one sample per cycle unless the result stalls; from req accept to rsp valid a sample passes
// the sample register, then magnitudes, compares and phase update into the result register
// the phase registers update in the same cycle a result is loaded, so samples follow back to back
// a stalled result holds the sample register; req ready drops only when both stages are full
// synchronous active-high reset: idle phase, register defaults, both stages empty
// depends on fdet_pkg, fdet_if, fdet_mag and fall_detector_fsm_macros.svh
`include "fall_detector_fsm_macros.svh"

module fall_detector_fsm (
   input  logic        clock,
   input  logic        reset,
   fdet_req_if.sink    req_bus,
   fdet_rsp_if.source  rsp_bus,
   fdet_csr_if.sink    csr_bus
);
   import fdet_pkg::*;

   // configuration registers
   logic [MAG_W-1:0]  freefall_mag_sq_ff;
   logic [MAG_W-1:0]  impact_mag_sq_ff;
   logic [MAG_W-1:0]  still_rate_sq_ff;
   logic [SPAN_W-1:0] freefall_max_ticks_ff;
   logic [SPAN_W-1:0] impact_wait_ticks_ff;
   logic [SPAN_W-1:0] post_window_ticks_ff;
   logic [SPAN_W-1:0] report_gap_ticks_ff;

   // sample register
   logic                     smp_valid_ff;
   logic                     smp_valid_in;
   logic signed [AXIS_W-1:0] smp_ax_ff, smp_ay_ff, smp_az_ff;
   logic signed [AXIS_W-1:0] smp_gx_ff, smp_gy_ff, smp_gz_ff;
   logic        [TICK_W-1:0] smp_ts_ff;

   // detector state
   phase_type          phase_ff, phase_in;
   logic [TICK_W-1:0]  start_tick_ff, start_tick_in;
   logic [TICK_W-1:0]  last_alarm_ff, last_alarm_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               alarm_ff, alarm_in;
   logic [CODE_W-1:0]  code_ff;

   logic              req_fire;
   logic              smp_fire;
   logic [MAG_W-1:0]  acc_mag;
   logic [MAG_W-1:0]  gyr_mag;
   logic [TICK_W-1:0] elapsed;
   logic [TICK_W-1:0] since_alarm;
   logic              acc_low;

   // ---------------- handshake ----------------
   assign smp_fire      = smp_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !smp_valid_ff || smp_fire;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign smp_valid_in = req_fire || (smp_valid_ff && !smp_fire);
   assign rsp_valid_in = smp_fire || (rsp_valid_ff && !rsp_bus.ready);

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.fall_alarm     = alarm_ff;
   assign rsp_bus.detector_state = code_ff;

   // ---------------- magnitudes ----------------
   fdet_mag u_acc_mag (
      .axis_x (smp_ax_ff),
      .axis_y (smp_ay_ff),
      .axis_z (smp_az_ff),
      .mag_sq (acc_mag)
   );

   fdet_mag u_gyr_mag (
      .axis_x (smp_gx_ff),
      .axis_y (smp_gy_ff),
      .axis_z (smp_gz_ff),
      .mag_sq (gyr_mag)
   );

   // ---------------- phase logic ----------------
   assign elapsed     = smp_ts_ff - start_tick_ff;
   assign since_alarm = smp_ts_ff - last_alarm_ff;
   assign acc_low     = acc_mag < freefall_mag_sq_ff;

   always_comb begin
      phase_in      = phase_ff;
      start_tick_in = start_tick_ff;
      last_alarm_in = last_alarm_ff;
      alarm_in      = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (acc_low) begin
               phase_in      = PH_FREEFALL;
               start_tick_in = smp_ts_ff;
            end
         end
         PH_FREEFALL: begin
            if (!acc_low) begin
               phase_in      = PH_IMPACT_WAIT;
               start_tick_in = smp_ts_ff;
            end else if (elapsed > {1'b0, freefall_max_ticks_ff}) begin
               phase_in = PH_IDLE;
            end
         end
         PH_IMPACT_WAIT: begin
            if (acc_mag > impact_mag_sq_ff) begin
               phase_in      = PH_POST;
               start_tick_in = smp_ts_ff;
            end else if (elapsed > {1'b0, impact_wait_ticks_ff}) begin
               phase_in = PH_IDLE;
            end
         end
         PH_POST: begin
            if (gyr_mag < still_rate_sq_ff) begin
               // wearer is still after the impact; alarm unless one was raised recently
               if (since_alarm > {1'b0, report_gap_ticks_ff}) begin
                  alarm_in      = 1'b1;
                  last_alarm_in = smp_ts_ff;
               end
               phase_in = PH_IDLE;
            end else if (elapsed > {1'b0, post_window_ticks_ff}) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_IDLE;
         start_tick_ff <= '0;
         last_alarm_ff <= '0;
      end else begin
         smp_valid_ff <= smp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (smp_fire) begin
            phase_ff      <= phase_in;
            start_tick_ff <= start_tick_in;
            last_alarm_ff <= last_alarm_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         smp_ax_ff <= req_bus.accel_x;
         smp_ay_ff <= req_bus.accel_y;
         smp_az_ff <= req_bus.accel_z;
         smp_gx_ff <= req_bus.gyro_x;
         smp_gy_ff <= req_bus.gyro_y;
         smp_gz_ff <= req_bus.gyro_z;
         smp_ts_ff <= req_bus.timestamp;
      end
      if (smp_fire) begin
         alarm_ff <= alarm_in;
         code_ff  <= phase_code(phase_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freefall_mag_sq_ff    <= RST_FREEFALL_MAG_SQ;
         impact_mag_sq_ff      <= RST_IMPACT_MAG_SQ;
         still_rate_sq_ff      <= RST_STILL_RATE_SQ;
         freefall_max_ticks_ff <= RST_FREEFALL_MAX_TICKS;
         impact_wait_ticks_ff  <= RST_IMPACT_WAIT_TICKS;
         post_window_ticks_ff  <= RST_POST_WINDOW_TICKS;
         report_gap_ticks_ff   <= RST_REPORT_GAP_TICKS;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_FREEFALL_MAG_SQ:    freefall_mag_sq_ff    <= csr_bus.data;
            REG_IMPACT_MAG_SQ:      impact_mag_sq_ff      <= csr_bus.data;
            REG_STILL_RATE_SQ:      still_rate_sq_ff      <= csr_bus.data;
            REG_FREEFALL_MAX_TICKS: freefall_max_ticks_ff <= csr_bus.data[SPAN_W-1:0];
            REG_IMPACT_WAIT_TICKS:  impact_wait_ticks_ff  <= csr_bus.data[SPAN_W-1:0];
            REG_POST_WINDOW_TICKS:  post_window_ticks_ff  <= csr_bus.data[SPAN_W-1:0];
            REG_REPORT_GAP_TICKS:   report_gap_ticks_ff   <= csr_bus.data[SPAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- assertions ----------------
   `FDET_ASSERT_NOW(a_alarm_idle, clock, reset, rsp_valid_ff && alarm_ff, code_ff == CODE_IDLE, "alarm raised outside idle")
   `FDET_ASSERT_NEXT(a_alarm_tick, clock, reset, smp_fire && alarm_in, last_alarm_ff == $past(smp_ts_ff), "alarm tick not recorded")
   `FDET_ASSERT_NEXT(a_phase_start, clock, reset, smp_fire && (phase_in != phase_ff) && (phase_in != PH_IDLE), start_tick_ff == $past(smp_ts_ff), "phase start tick not taken")
   `FDET_ASSERT_NOW(a_code_match, clock, reset, rsp_valid_ff && !smp_fire, code_ff == phase_code(phase_ff), "result state differs from phase")

endmodule
